[src/cfd_pkg.sv]
// Shared constants, register indexes, opcodes and types for the complex FIR decimator.
// No dependencies; every other file of the block but cfd_ram refers to it by scoped names.

package cfd_pkg;

	localparam int MAX_TAPS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS_DEF   = 18;

	localparam int DECIM_W     = 5;
	localparam int TAPS_CFG_W  = 7;
	localparam int PHASE_W     = 4;
	localparam int COEF_IDX_W  = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic [DECIM_W-1:0] DECIM_RESET = 5'd10;
	localparam logic [DECIM_W-1:0] DECIM_MAX   = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_DECIM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 1'b1;

	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic clear;
		logic tap_vld;
		logic last;
	} mac_ctl_t;

endpackage

[src/cfd_ifs.sv]
// Valid/ready channel interfaces for the input and result beats of the decimator.
// Depends on cfd_pkg for default widths.

interface cfd_in_if #(
	parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = cfd_pkg::COEF_BITS_DEF
);
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [cfd_pkg::COEF_IDX_W-1:0]      coef_index;
	logic signed [COEF_BITS-1:0]         coef_value;
	logic signed [SAMPLE_BITS-1:0]       in_i;
	logic signed [SAMPLE_BITS-1:0]       in_q;

	modport source (output valid, op, coef_index, coef_value, in_i, in_q, input ready);
	modport sink (input valid, op, coef_index, coef_value, in_i, in_q, output ready);
endinterface

interface cfd_out_if #(
	parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_i;
	logic signed [SAMPLE_BITS-1:0] out_q;

	modport source (output valid, out_i, out_q, input ready);
	modport sink (input valid, out_i, out_q, output ready);
endinterface

[src/cfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module cfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/cfd_mac.sv]
// Shared complex-by-real multiply-accumulate unit with final rounding and saturation.
// Depends on cfd_pkg for the control struct.

module cfd_mac #(
	parameter int MAX_TAPS    = cfd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = cfd_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfd_pkg::mac_ctl_t             ctl,
	input  logic signed [SAMPLE_BITS-1:0] smp_i,
	input  logic signed [SAMPLE_BITS-1:0] smp_q,
	input  logic signed [COEF_BITS-1:0]   coef,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] res_i,
	output logic signed [SAMPLE_BITS-1:0] res_q
);

	localparam int PW    = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;
	localparam int SH    = COEF_BITS - 1;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_BITS - 2);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

	logic                      vld_s2;
	logic                      last_s2;
	logic signed [PW-1:0]      prod_i_s2;
	logic signed [PW-1:0]      prod_q_s2;
	logic signed [ACC_W-1:0]   acc_i_q;
	logic signed [ACC_W-1:0]   acc_q_q;
	logic                      end_q;
	logic                      rnd_vld_q;
	logic signed [ACC_W-1:0]   rnd_i_q;
	logic signed [ACC_W-1:0]   rnd_q_q;
	logic                      done_q;
	logic signed [SAMPLE_BITS-1:0] res_i_q;
	logic signed [SAMPLE_BITS-1:0] res_q_q;

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			last_s2   <= 1'b0;
			end_q     <= 1'b0;
			rnd_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			vld_s2    <= ctl.tap_vld;
			last_s2   <= ctl.tap_vld && ctl.last;
			end_q     <= vld_s2 && last_s2;
			rnd_vld_q <= end_q;
			done_q    <= rnd_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_i_s2 <= smp_i * coef;
		prod_q_s2 <= smp_q * coef;
		if (ctl.clear) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (vld_s2) begin
			acc_i_q <= acc_i_q + {{(ACC_W-PW){prod_i_s2[PW-1]}}, prod_i_s2};
			acc_q_q <= acc_q_q + {{(ACC_W-PW){prod_q_s2[PW-1]}}, prod_q_s2};
		end
		if (end_q) begin
			rnd_i_q <= (acc_i_q + RND_HALF) >>> SH;
			rnd_q_q <= (acc_q_q + RND_HALF) >>> SH;
		end
		if (rnd_vld_q) begin
			res_i_q <= sat(rnd_i_q);
			res_q_q <= sat(rnd_q_q);
		end
	end

	assign done  = done_q;
	assign res_i = res_i_q;
	assign res_q = res_q_q;

endmodule

[src/complex_fir_decimator_top.sv]
// Top level of the complex I/Q FIR decimator: sequencer, coefficient and window RAMs,
// output register. Depends on cfd_pkg, cfd_ifs, cfd_ram and cfd_mac.
//
//   Channel   Direction  Beat contents
//   in_ch     sink       op, coef_index, coef_value, in_i, in_q
//   out_ch    source     out_i, out_q
//   cfg       write      cfg_we, cfg_index, cfg_data
//
// A coefficient beat and a sample beat that makes no output leave the sequencer idle.
// A sample beat that makes an output starts a sum in which one tap per cycle
// goes through the single read port of each RAM and the one shared MAC unit.
// After reset all taps and window entries read as zero through per-entry valid bits.
// A finished result waits in the output register while new beats are taken; the
// sequencer holds at the end of a sum only while that register is still full.

module complex_fir_decimator_top #(
	parameter int MAX_TAPS    = cfd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = cfd_pkg::COEF_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfd_pkg::CFG_DATA_W-1:0]    cfg_data,
	cfd_in_if.sink                            in_ch,
	cfd_out_if.source                         out_ch
);

	localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TW  = $clog2(MAX_TAPS + 1);
	localparam int TCW = (TW > cfd_pkg::TAPS_CFG_W) ? TW : cfd_pkg::TAPS_CFG_W;
	localparam int SW  = 2 * SAMPLE_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_HOLD
	} state_t;

	state_t                         state_q;
	logic [cfd_pkg::DECIM_W-1:0]    dec_q;
	logic [TCW-1:0]                 taps_q;
	logic [cfd_pkg::PHASE_W-1:0]    phase_q;
	logic [AW-1:0]                  head_q;
	logic [TW-1:0]                  k_q;
	logic [AW-1:0]                  pos_q;
	logic [MAX_TAPS-1:0]            coef_vld_q;
	logic [MAX_TAPS-1:0]            win_vld_q;
	logic                           rd_s1;
	logic                           last_s1;
	logic                           cv_s1;
	logic                           wv_s1;
	logic                           out_vld_q;
	logic signed [SAMPLE_BITS-1:0]  out_i_q;
	logic signed [SAMPLE_BITS-1:0]  out_q_q;

	logic                           accept;
	logic                           coef_we;
	logic                           win_we;
	logic                           emit;
	logic [cfd_pkg::DECIM_W-1:0]    dec_eff;
	logic [TW-1:0]                  taps_eff;
	logic [cfd_pkg::DECIM_W-1:0]    phase_inc;
	logic [cfd_pkg::PHASE_W-1:0]    phase_nxt;
	logic [AW-1:0]                  head_nxt;
	logic [AW:0]                    pos_sum;
	logic [AW-1:0]                  pos_start;
	logic [AW-1:0]                  pos_inc;
	logic                           k_last;
	logic                           out_free;
	logic [AW-1:0]                  coef_waddr;
	logic [AW-1:0]                  coef_raddr;
	logic [COEF_BITS-1:0]           coef_rdata;
	logic [SW-1:0]                  win_rdata;
	logic signed [SAMPLE_BITS-1:0]  smp_i;
	logic signed [SAMPLE_BITS-1:0]  smp_q;
	logic signed [COEF_BITS-1:0]    coef;
	cfd_pkg::mac_ctl_t              mac_ctl;
	logic                           mac_done;
	logic signed [SAMPLE_BITS-1:0]  res_i;
	logic signed [SAMPLE_BITS-1:0]  res_q;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign coef_we     = accept && (in_ch.op == cfd_pkg::OP_COEF)
	                     && (32'(in_ch.coef_index) < MAX_TAPS);
	assign win_we      = accept && (in_ch.op == cfd_pkg::OP_SAMPLE);
	assign emit        = win_we && (phase_q == '0);
	assign coef_waddr  = AW'(in_ch.coef_index);
	assign coef_raddr  = AW'(k_q);

	always_comb begin
		if (dec_q == '0) begin
			dec_eff = cfd_pkg::DECIM_W'(1);
		end else if (dec_q > cfd_pkg::DECIM_MAX) begin
			dec_eff = cfd_pkg::DECIM_MAX;
		end else begin
			dec_eff = dec_q;
		end
		if (taps_q == '0) begin
			taps_eff = TW'(1);
		end else if (taps_q > TCW'(MAX_TAPS)) begin
			taps_eff = TW'(MAX_TAPS);
		end else begin
			taps_eff = TW'(taps_q);
		end
	end

	assign phase_inc = {1'b0, phase_q} + cfd_pkg::DECIM_W'(1);
	assign phase_nxt = (phase_inc >= dec_eff) ? '0 : phase_inc[cfd_pkg::PHASE_W-1:0];
	assign head_nxt  = (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
	assign pos_sum   = {1'b0, head_nxt} + (AW+1)'(MAX_TAPS) - (AW+1)'(taps_eff) + (AW+1)'(1);
	assign pos_start = (pos_sum >= (AW+1)'(MAX_TAPS)) ? AW'(pos_sum - (AW+1)'(MAX_TAPS))
	                                                  : AW'(pos_sum);
	assign pos_inc   = (pos_q == AW'(MAX_TAPS - 1)) ? '0 : pos_q + AW'(1);
	assign k_last    = (k_q == taps_eff - TW'(1));
	assign out_free  = !out_vld_q || out_ch.ready;

	cfd_ram #(
		.WIDTH (COEF_BITS),
		.DEPTH (MAX_TAPS),
		.AW    (AW)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (in_ch.coef_value),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	cfd_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_TAPS),
		.AW    (AW)
	) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (head_nxt),
		.wdata ({in_ch.in_i, in_ch.in_q}),
		.raddr (pos_q),
		.rdata (win_rdata)
	);

	assign smp_i = wv_s1 ? win_rdata[SW-1:SAMPLE_BITS] : '0;
	assign smp_q = wv_s1 ? win_rdata[SAMPLE_BITS-1:0] : '0;
	assign coef  = cv_s1 ? coef_rdata : '0;

	always_comb begin
		mac_ctl.clear   = emit;
		mac_ctl.tap_vld = rd_s1;
		mac_ctl.last    = last_s1;
	end

	cfd_mac #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.smp_i  (smp_i),
		.smp_q  (smp_q),
		.coef   (coef),
		.done   (mac_done),
		.res_i  (res_i),
		.res_q  (res_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dec_q      <= cfd_pkg::DECIM_RESET;
			taps_q     <= TCW'(MAX_TAPS);
			phase_q    <= '0;
			head_q     <= '0;
			k_q        <= '0;
			pos_q      <= '0;
			coef_vld_q <= '0;
			win_vld_q  <= '0;
			rd_s1      <= 1'b0;
			last_s1    <= 1'b0;
			cv_s1      <= 1'b0;
			wv_s1      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cfd_pkg::REG_DECIM: begin
						dec_q <= cfg_data[cfd_pkg::DECIM_W-1:0];
					end
					cfd_pkg::REG_TAPS: begin
						taps_q <= TCW'(cfg_data[cfd_pkg::TAPS_CFG_W-1:0]);
					end
					default: begin
					end
				endcase
			end

			if (coef_we) begin
				coef_vld_q[coef_waddr] <= 1'b1;
			end

			if ((state_q == S_HOLD) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end

			rd_s1   <= (state_q == S_RUN);
			last_s1 <= (state_q == S_RUN) && k_last;

			case (state_q)
				S_IDLE: begin
					if (win_we) begin
						head_q              <= head_nxt;
						win_vld_q[head_nxt] <= 1'b1;
						phase_q             <= phase_nxt;
						if (emit) begin
							k_q     <= '0;
							pos_q   <= pos_start;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					cv_s1   <= coef_vld_q[coef_raddr];
					wv_s1   <= win_vld_q[pos_q];
					k_q     <= k_q + TW'(1);
					pos_q   <= pos_inc;
					if (k_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (mac_done) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_HOLD) && out_free) begin
			out_i_q <= res_i;
			out_q_q <= res_q;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.out_i = out_i_q;
	assign out_ch.out_q = out_q_q;

endmodule

[bench/cfd_scoreboard.sv]
// Scoreboard for the complex FIR decimator: tracks taps, sample history and phase,
// predicts each filtered output and compares it with the result beats in order.
// Depends on cfd_pkg and the channel interfaces in cfd_ifs.

module cfd_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data,
	cfd_in_if                              in_ch,
	cfd_out_if                             out_ch,
	output int                             outstanding,
	output int                             mismatches
);

	localparam int TAPS = cfd_pkg::MAX_TAPS_DEF;
	localparam int SW   = cfd_pkg::SAMPLE_BITS_DEF;
	localparam int CW   = cfd_pkg::COEF_BITS_DEF;
	localparam int PW   = $clog2(TAPS);
	localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
	} iq_t;

	logic signed [CW-1:0]          coef [TAPS];
	logic signed [SW-1:0]          hist_i [TAPS];
	logic signed [SW-1:0]          hist_q [TAPS];
	logic [PW-1:0]                 head;
	logic [cfd_pkg::PHASE_W-1:0]   phase;
	logic [cfd_pkg::DECIM_W-1:0]   decim;
	logic [cfd_pkg::TAPS_CFG_W-1:0] ntaps;
	iq_t                           filtered_q [$];
	int                            fail_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	// Round half up from Q2.32 down to Q1.15, then clamp to the sample range.
	function automatic logic signed [SW-1:0] round_sat(input longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (CW - 2))) >>> (CW - 1);
		if (q > SAT_HI)
			q = SAT_HI;
		if (q < SAT_LO)
			q = SAT_LO;
		return q[SW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int            dec_eff;
		int            taps_eff;
		int            nxt;
		logic          emit;
		longint        acc_i;
		longint        acc_q;
		logic [PW-1:0] pos;
		iq_t           got;
		iq_t           want;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				coef[k] = '0;
				hist_i[k] = '0;
				hist_q[k] = '0;
			end
			head = '0;
			phase = '0;
			decim = cfd_pkg::DECIM_RESET;
			ntaps = cfd_pkg::TAPS_CFG_W'(TAPS);
			filtered_q.delete();
			outstanding <= 0;
		end else begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.re = out_ch.out_i;
				got.im = out_ch.out_q;
				if (filtered_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat i=%0d q=%0d",
						got.re, got.im));
				end else begin
					want = filtered_q.pop_front();
					if (got.re !== want.re)
						report_mismatch($sformatf("out_i %0d, expected %0d", got.re, want.re));
					if (got.im !== want.im)
						report_mismatch($sformatf("out_q %0d, expected %0d", got.im, want.im));
				end
			end
			if (cfg_we) begin
				if (cfg_index == cfd_pkg::REG_DECIM)
					decim = cfg_data[cfd_pkg::DECIM_W-1:0];
				else if (cfg_index == cfd_pkg::REG_TAPS)
					ntaps = cfg_data[cfd_pkg::TAPS_CFG_W-1:0];
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
				if (in_ch.op == cfd_pkg::OP_COEF) begin
					coef[in_ch.coef_index] = in_ch.coef_value;
				end else begin
					head = head + 1'b1;
					hist_i[head] = in_ch.in_i;
					hist_q[head] = in_ch.in_q;
					dec_eff = (decim == 0) ? 1 :
						(decim > cfd_pkg::DECIM_MAX) ? int'(cfd_pkg::DECIM_MAX) : int'(decim);
					taps_eff = (ntaps == 0) ? 1 : (ntaps > TAPS) ? TAPS : int'(ntaps);
					emit = (phase == 0);
					nxt = int'(phase) + 1;
					phase = (nxt >= dec_eff) ? '0 : nxt[cfd_pkg::PHASE_W-1:0];
					if (emit) begin
						acc_i = 0;
						acc_q = 0;
						// The newest sample meets the highest tap in use.
						for (int k = 0; k < taps_eff; k++) begin
							pos = head - PW'(taps_eff - 1 - k);
							acc_i += longint'(hist_i[pos]) * longint'(coef[k]);
							acc_q += longint'(hist_q[pos]) * longint'(coef[k]);
						end
						want.re = round_sat(acc_i);
						want.im = round_sat(acc_q);
						filtered_q.insert(filtered_q.size(), want);
					end
				end
			end
			outstanding <= filtered_q.size();
		end
	end

endmodule

[bench/tb_complex_fir_decimator_top.sv]
// Top of the decimator bench: clock, reset, register writes, input beats and the
// result-side ready, with the verdict at the end. Depends on cfd_pkg, cfd_ifs,
// complex_fir_decimator_top and cfd_scoreboard.

module tb_complex_fir_decimator_top;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int SETTLE          = cfd_pkg::MAX_TAPS_DEF + 16;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SW              = cfd_pkg::SAMPLE_BITS_DEF;
	localparam int CW              = cfd_pkg::COEF_BITS_DEF;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index = cfd_pkg::REG_DECIM;
	logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_op = cfd_pkg::OP_SAMPLE;
	logic [cfd_pkg::COEF_IDX_W-1:0] in_idx = '0;
	logic [CW-1:0]                  in_coef = '0;
	logic [SW-1:0]                  in_i = '0;
	logic [SW-1:0]                  in_q = '0;
	logic                           rx_ready = 1'b0;
	int                             tx_idle_pct = 17;
	int                             rx_idle_pct = 50;
	int                             cycles = 0;
	int                             outstanding;
	int                             mismatches;
	logic [cfd_pkg::CFG_DATA_W-1:0] decim_plan [PHASES] = '{1, 16, 0, 17, 127, 3, 0, 2, 0, 1, 0, 0};
	logic [cfd_pkg::CFG_DATA_W-1:0] taps_plan [PHASES] = '{64, 1, 0, 65, 127, 2, 0, 32, 0, 1, 0, 0};

	cfd_in_if  in_ch ();
	cfd_out_if out_ch ();

	assign in_ch.valid      = in_valid;
	assign in_ch.op         = in_op;
	assign in_ch.coef_index = in_idx;
	assign in_ch.coef_value = in_coef;
	assign in_ch.in_i       = in_i;
	assign in_ch.in_q       = in_q;
	assign out_ch.ready     = rx_ready;

	complex_fir_decimator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	cfd_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rx_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [SW-1:0] pick_sample();
		logic [SW-1:0] v;
		case ($urandom_range(7))
			0: v = {1'b0, {(SW-1){1'b1}}};
			1: v = {1'b1, {(SW-1){1'b0}}};
			default: v = SW'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [CW-1:0] pick_coef();
		logic [CW-1:0] v;
		case ($urandom_range(7))
			0: v = {1'b0, {(CW-1){1'b1}}};
			1: v = {1'b1, {(CW-1){1'b0}}};
			default: v = CW'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_beat(input logic op, input logic [cfd_pkg::COEF_IDX_W-1:0] idx,
			input logic [CW-1:0] cv, input logic [SW-1:0] si, input logic [SW-1:0] sq);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_op <= op;
		in_idx <= idx;
		in_coef <= cv;
		in_i <= si;
		in_q <= sq;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	// Coefficient beats and non-output samples give no result, so the block may
	// still be busy when the last result is in; give it a full sum's worth of time.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_rates(input logic [cfd_pkg::CFG_DATA_W-1:0] decim_val,
			input logic [cfd_pkg::CFG_DATA_W-1:0] taps_val);
		cfg_we <= 1'b1;
		cfg_index <= cfd_pkg::REG_DECIM;
		cfg_data <= decim_val;
		@(posedge clk);
		cfg_index <= cfd_pkg::REG_TAPS;
		cfg_data <= taps_val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		decim_plan[6] = cfd_pkg::CFG_DATA_W'($urandom_range(16, 1));
		taps_plan[6] = cfd_pkg::CFG_DATA_W'($urandom_range(64, 1));
		decim_plan[8] = cfd_pkg::CFG_DATA_W'($urandom_range(16, 1));
		taps_plan[8] = cfd_pkg::CFG_DATA_W'($urandom_range(8, 1));
		decim_plan[10] = cfd_pkg::CFG_DATA_W'($urandom_range(127));
		taps_plan[10] = cfd_pkg::CFG_DATA_W'($urandom_range(127));
		decim_plan[11] = cfd_pkg::CFG_DATA_W'($urandom_range(4, 1));
		taps_plan[11] = cfd_pkg::CFG_DATA_W'($urandom_range(64, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the first sample makes an output, the next one does not.
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'h7fff, 16'h8000);
		send_beat(cfd_pkg::OP_SAMPLE, '1, '1, 16'h0001, 16'hffff);
		drain();

		// Two taps, no decimation: saturation at both ends, then rounding ties.
		set_rates(1, 2);
		send_beat(cfd_pkg::OP_COEF, 6'd0, 18'h1ffff, '0, '0);
		send_beat(cfd_pkg::OP_COEF, 6'd1, 18'h1ffff, '0, '0);
		send_beat(cfd_pkg::OP_COEF, 6'd63, 18'h20000, '0, '0);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'h7fff, 16'h8000);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'h7fff, 16'h8000);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'hffff, 16'h0000);
		send_beat(cfd_pkg::OP_COEF, 6'd0, 18'h00000, '0, '0);
		send_beat(cfd_pkg::OP_COEF, 6'd1, 18'h00001, '0, '0);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'hffff, 16'h0001);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'h0000, 16'h0000);
		send_beat(cfd_pkg::OP_COEF, 6'd1, 18'h10000, '0, '0);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'h0001, 16'hffff);
		send_beat(cfd_pkg::OP_COEF, 6'd1, 18'h20000, '0, '0);
		send_beat(cfd_pkg::OP_SAMPLE, '0, '0, 16'h8000, 16'h7fff);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 4) begin
				tx_idle_pct = 50;
				rx_idle_pct <= 17;
			end else if (p == 8) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			set_rates(decim_plan[p], taps_plan[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 12)
					send_beat(cfd_pkg::OP_COEF,
						cfd_pkg::COEF_IDX_W'($urandom_range(1) ? $urandom_range(63)
							: $urandom_range(7)),
						pick_coef(), SW'($urandom), SW'($urandom));
				else
					send_beat(cfd_pkg::OP_SAMPLE, cfd_pkg::COEF_IDX_W'($urandom),
						CW'($urandom), pick_sample(), pick_sample());
			end
		end
		drain();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
